>>> rtl/ppsts_pkg.sv
`default_nettype none

package ppsts_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_CAPTURE_MODE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ASSERT_OFFSET_SEC  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ASSERT_OFFSET_NSEC = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLEAR_OFFSET_SEC   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLEAR_OFFSET_NSEC  = 3'd4;

    localparam int unsigned MODE_CAPTURE_ASSERT = 0;
    localparam int unsigned MODE_CAPTURE_CLEAR  = 1;
    localparam int unsigned MODE_OFFSET_ASSERT  = 2;
    localparam int unsigned MODE_OFFSET_CLEAR   = 3;

    localparam int unsigned EDGE_ASSERT = 0;
    localparam int unsigned EDGE_CLEAR  = 1;

    localparam logic signed [31:0] ONE_SEC_NS = 32'sd1000000000;
    localparam logic signed [31:0] TWO_SEC_NS = 32'sd2000000000;

    typedef struct packed {
        logic [1:0]         edge_kind;
        logic signed [63:0] stamp_sec;
        logic [29:0]        stamp_nsec;
    } pulse_item_t;

    typedef struct packed {
        logic               captured;
        logic signed [63:0] assert_sec;
        logic [29:0]        assert_nsec;
        logic [31:0]        assert_count;
        logic signed [63:0] clear_sec;
        logic [29:0]        clear_nsec;
        logic [31:0]        clear_count;
        logic [31:0]        event_total;
    } capture_item_t;

    typedef struct packed {
        logic [63:0] sec;
        logic [29:0] nsec;
    } stamp_t;

    // The nanosecond sum lies in [-2^30, 2^31 - 2], so the carry into the
    // seconds is one of -2, -1, 0, 1 or 2.
    function automatic stamp_t add_offset(
        input stamp_t             stamp,
        input logic [63:0]        off_sec,
        input logic signed [30:0] off_nsec
    );
        logic signed [31:0] sum;
        logic signed [31:0] adj;
        logic [31:0]        diff;
        logic [63:0]        carry;
        stamp_t             res;
        sum = $signed({2'b00, stamp.nsec}) + $signed({off_nsec[30], off_nsec});
        if (sum >= TWO_SEC_NS) begin
            adj   = TWO_SEC_NS;
            carry = 64'd2;
        end else if (sum >= ONE_SEC_NS) begin
            adj   = ONE_SEC_NS;
            carry = 64'd1;
        end else if (sum >= 32'sd0) begin
            adj   = 32'sd0;
            carry = 64'd0;
        end else if (sum >= -ONE_SEC_NS) begin
            adj   = -ONE_SEC_NS;
            carry = 64'hFFFF_FFFF_FFFF_FFFF;
        end else begin
            adj   = -TWO_SEC_NS;
            carry = 64'hFFFF_FFFF_FFFF_FFFE;
        end
        diff     = 32'(sum - adj);
        res.nsec = diff[29:0];
        res.sec  = stamp.sec + off_sec + carry;
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/pps_edge_timestamp_capture_core.sv
// PPS edge timestamp capture.
// Input channel pulse_valid/pulse_ready/pulse carries one pulse event: edge
// flags and a seconds and nanoseconds timestamp. Output channel
// capture_valid/capture_ready/capture returns exactly one item per event with
// the capture registers as they stand after that event.
// Configuration is written through cfg_write, cfg_index and cfg_data while
// the block is idle (the user's duty, unchecked); unknown indexes are ignored.
// The block is a two-stage pipeline: the first stage applies the assert
// offset, the second applies the clear offset and updates the capture
// registers and counters, which drive the output directly.
// capture_valid rises once an accepted item has moved from the first-stage
// register into the output registers. One item is accepted every cycle
// while the receiver keeps capture_ready high.
// When the receiver stalls, the output item holds, the first stage fills,
// and pulse_ready then drops until the output item is taken.
// Reset clears the configuration, the capture registers and all counters.
`default_nettype none

module pps_edge_timestamp_capture_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_write,
    input  wire logic [ppsts_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [ppsts_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                  pulse_valid,
    output      logic                                  pulse_ready,
    input  wire ppsts_pkg::pulse_item_t                pulse,
    output      logic                                  capture_valid,
    input  wire logic                                  capture_ready,
    output      ppsts_pkg::capture_item_t              capture
);

    logic [3:0]         mode_reg;
    logic [63:0]        assert_off_sec_reg;
    logic signed [30:0] assert_off_nsec_reg;
    logic [63:0]        clear_off_sec_reg;
    logic signed [30:0] clear_off_nsec_reg;

    logic                p1_valid_reg;
    logic                p1_assert_reg;
    logic                p1_clear_reg;
    ppsts_pkg::stamp_t   p1_stamp_reg;
    logic                p1_assert_next;
    logic                p1_clear_next;
    ppsts_pkg::stamp_t   p1_stamp_next;
    ppsts_pkg::stamp_t   raw_stamp;

    logic                out_valid_reg;
    logic                captured_reg;
    ppsts_pkg::stamp_t   assert_stamp_reg;
    logic [31:0]         assert_count_reg;
    ppsts_pkg::stamp_t   clear_stamp_reg;
    logic [31:0]         clear_count_reg;
    logic [31:0]         total_reg;
    ppsts_pkg::stamp_t   clear_stamp_next;

    logic out_free;
    logic p1_advance;
    logic pulse_accept;

    assign out_free     = !out_valid_reg || capture_ready;
    assign p1_advance   = p1_valid_reg && out_free;
    assign pulse_ready  = !p1_valid_reg || out_free;
    assign pulse_accept = pulse_valid && pulse_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg            <= '0;
            assert_off_sec_reg  <= '0;
            assert_off_nsec_reg <= '0;
            clear_off_sec_reg   <= '0;
            clear_off_nsec_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ppsts_pkg::CFG_CAPTURE_MODE:       mode_reg            <= cfg_data[3:0];
                ppsts_pkg::CFG_ASSERT_OFFSET_SEC:  assert_off_sec_reg  <= cfg_data;
                ppsts_pkg::CFG_ASSERT_OFFSET_NSEC: assert_off_nsec_reg <= $signed(cfg_data[30:0]);
                ppsts_pkg::CFG_CLEAR_OFFSET_SEC:   clear_off_sec_reg   <= cfg_data;
                ppsts_pkg::CFG_CLEAR_OFFSET_NSEC:  clear_off_nsec_reg  <= $signed(cfg_data[30:0]);
                default:
                begin
                end
            endcase
        end
    end

    // First stage: decide which edges are captured and apply the assert offset.
    always_comb
    begin
        raw_stamp.sec  = pulse.stamp_sec;
        raw_stamp.nsec = pulse.stamp_nsec;
        p1_assert_next = pulse.edge_kind[ppsts_pkg::EDGE_ASSERT]
                         && mode_reg[ppsts_pkg::MODE_CAPTURE_ASSERT];
        p1_clear_next  = pulse.edge_kind[ppsts_pkg::EDGE_CLEAR]
                         && mode_reg[ppsts_pkg::MODE_CAPTURE_CLEAR];
        if (p1_assert_next && mode_reg[ppsts_pkg::MODE_OFFSET_ASSERT])
        begin
            p1_stamp_next = ppsts_pkg::add_offset(raw_stamp, assert_off_sec_reg,
                                                  assert_off_nsec_reg);
        end
        else
        begin
            p1_stamp_next = raw_stamp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else if (pulse_ready)
        begin
            p1_valid_reg <= pulse_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pulse_accept)
        begin
            p1_assert_reg <= p1_assert_next;
            p1_clear_reg  <= p1_clear_next;
            p1_stamp_reg  <= p1_stamp_next;
        end
    end

    // Second stage: apply the clear offset on top of the first-stage stamp.
    always_comb
    begin
        if (mode_reg[ppsts_pkg::MODE_OFFSET_CLEAR])
        begin
            clear_stamp_next = ppsts_pkg::add_offset(p1_stamp_reg, clear_off_sec_reg,
                                                     clear_off_nsec_reg);
        end
        else
        begin
            clear_stamp_next = p1_stamp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            captured_reg     <= 1'b0;
            assert_stamp_reg <= '0;
            assert_count_reg <= '0;
            clear_stamp_reg  <= '0;
            clear_count_reg  <= '0;
            total_reg        <= '0;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg <= p1_valid_reg;
            end
            if (p1_advance)
            begin
                captured_reg <= p1_assert_reg || p1_clear_reg;
                if (p1_assert_reg)
                begin
                    assert_stamp_reg <= p1_stamp_reg;
                    assert_count_reg <= assert_count_reg + 32'd1;
                end
                if (p1_clear_reg)
                begin
                    clear_stamp_reg <= clear_stamp_next;
                    clear_count_reg <= clear_count_reg + 32'd1;
                end
                if (p1_assert_reg || p1_clear_reg)
                begin
                    total_reg <= total_reg + 32'd1;
                end
            end
        end
    end

    assign capture_valid        = out_valid_reg;
    assign capture.captured     = captured_reg;
    assign capture.assert_sec   = $signed(assert_stamp_reg.sec);
    assign capture.assert_nsec  = assert_stamp_reg.nsec;
    assign capture.assert_count = assert_count_reg;
    assign capture.clear_sec    = $signed(clear_stamp_reg.sec);
    assign capture.clear_nsec   = clear_stamp_reg.nsec;
    assign capture.clear_count  = clear_count_reg;
    assign capture.event_total  = total_reg;

    a_total_tracks_captured: assert property (
        @(posedge clk) disable iff (!rst_n)
        p1_advance |=> (total_reg == $past(total_reg) + {31'd0, captured_reg})
    ) else $error("event total does not follow the captured flag");

    a_captured_matches_counts: assert property (
        @(posedge clk) disable iff (!rst_n)
        p1_advance |=> (captured_reg == ((assert_count_reg != $past(assert_count_reg))
                                         || (clear_count_reg != $past(clear_count_reg))))
    ) else $error("captured flag disagrees with the sequence counts");

    a_assert_nsec_normalized: assert property (
        @(posedge clk) disable iff (!rst_n)
        (pulse_accept && p1_assert_next && mode_reg[ppsts_pkg::MODE_OFFSET_ASSERT])
        |=> ($signed({2'b00, p1_stamp_reg.nsec}) < ppsts_pkg::ONE_SEC_NS)
    ) else $error("assert nanoseconds left unnormalized after offset");

    a_stage_holds_on_stall: assert property (
        @(posedge clk) disable iff (!rst_n)
        (p1_valid_reg && !out_free) |=> (p1_valid_reg && $stable(p1_stamp_reg))
    ) else $error("first stage item lost while output stalled");

endmodule

`default_nettype wire
